FILE: rtl/fep_pkg.sv
`default_nettype none

package fep_pkg;

   // fraction bits of the fixed point format
   localparam int FRAC_BITS = 16;

   localparam int ELEM_WIDTH = 32;
   localparam int SUM_WIDTH  = 64;

   typedef struct packed {
      logic                         which_matrix;
      logic [3:0]                   element_index;
      logic signed [ELEM_WIDTH-1:0] element_value;
      logic                         start_compute;
   } req_type;

   typedef struct packed {
      logic [2:0]                   plane_number;
      logic [1:0]                   component;
      logic signed [ELEM_WIDTH-1:0] coefficient;
      logic                         degenerate;
      logic                         final_result;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/fep_ram.sv
`default_nettype none

module fep_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/frustum_plane_extraction.sv
`default_nettype none

// Frustum plane extractor. Matrix elements are written one item per cycle into
// the modelview and projection stores while req_stall is low. An item with
// start_compute set is stored and then starts the compute, during which
// req_stall is high: the combined matrix is built with one shared 32x32
// multiplier, each product passing through the read, multiply and accumulate
// states, then each plane forms its components, applies normalizing shifts,
// sums the squares, takes a bit-serial square root and runs a bit-serial
// divide per coefficient. Degenerate planes skip the divide and emit zero
// coefficients. It emits 24 result items, plane-major, x y z w per plane.
module frustum_plane_extraction (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire fep_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output fep_pkg::rsp_type      rsp_data
);

   import fep_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_MREAD, S_MMUL, S_MACC, S_RDA, S_RDB, S_CMB, S_NORM,
      S_SQM, S_SQA, S_SQRT, S_CHK, S_DIVI, S_DIV, S_EMIT
   } state_type;

   state_type                 state_ff;
   logic [5:0]                cnt_ff;
   logic [2:0]                plane_ff;
   logic [1:0]                comp_ff;
   logic [5:0]                step_ff;
   logic signed [63:0]        acc_ff;
   logic signed [63:0]        prod_ff;
   logic signed [63:0]        a_ff;
   logic [63:0]               mag_ff [4];
   logic [3:0]                neg_ff;
   logic [63:0]               mx_ff;
   logic [63:0]               sum_ff;
   logic [63:0]               n_ff;
   logic [63:0]               res_ff;
   logic [63:0]               num_ff;
   logic [32:0]               rem_ff;
   logic [63:0]               q_ff;
   logic                      degen_ff;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_ff;

   logic                      accept;
   logic [ELEM_WIDTH-1:0]     mv_rdata;
   logic [ELEM_WIDTH-1:0]     pj_rdata;
   logic [SUM_WIDTH-1:0]      cm_rdata;
   logic [3:0]                cm_raddr;
   logic                      cm_we;
   logic signed [31:0]        mul_a;
   logic signed [31:0]        mul_b;
   logic [63:0]               prod_mag;
   logic [63:0]               prod_sh;
   logic signed [63:0]        scaled;
   logic signed [63:0]        acc_in;
   logic signed [63:0]        v_in;
   logic [63:0]               vmag;
   logic [63:0]               sqrt_bit;
   logic [63:0]               sqrt_try;
   logic [33:0]               rem_in;
   logic [33:0]               len_ext;
   logic [63:0]               q_sat;
   logic [31:0]               coef;
   logic                      out_free;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // matrix stores and combined matrix
   fep_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(16)) u_mv_ram (
      .clock   (clock),
      .wr_en   (accept && !req_data.which_matrix),
      .wr_addr (req_data.element_index),
      .wr_data (req_data.element_value),
      .rd_addr ({cnt_ff[5:4], cnt_ff[1:0]}),
      .rd_data (mv_rdata)
   );

   fep_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(16)) u_pj_ram (
      .clock   (clock),
      .wr_en   (accept && req_data.which_matrix),
      .wr_addr (req_data.element_index),
      .wr_data (req_data.element_value),
      .rd_addr ({cnt_ff[1:0], cnt_ff[3:2]}),
      .rd_data (pj_rdata)
   );

   assign cm_we    = (state_ff == S_MACC) && (cnt_ff[1:0] == 2'd3);
   assign cm_raddr = (state_ff == S_RDA) ? {comp_ff, 2'b11} : {comp_ff, plane_ff[2:1]};

   fep_ram #(.WIDTH(SUM_WIDTH), .DEPTH(16)) u_cm_ram (
      .clock   (clock),
      .wr_en   (cm_we),
      .wr_addr (cnt_ff[5:2]),
      .wr_data (acc_in),
      .rd_addr (cm_raddr),
      .rd_data (cm_rdata)
   );

   // shared multiplier operands
   always_comb begin
      if (state_ff == S_MMUL) begin
         mul_a = mv_rdata;
         mul_b = pj_rdata;
      end else begin
         mul_a = {1'b0, mag_ff[comp_ff][30:0]};
         mul_b = {1'b0, mag_ff[comp_ff][30:0]};
      end
   end

   // product scaled back with truncation toward zero
   always_comb begin
      prod_mag = prod_ff[63] ? 64'(-prod_ff) : 64'(prod_ff);
      prod_sh  = prod_mag >> FRAC_BITS;
      scaled   = prod_ff[63] ? -$signed(prod_sh) : $signed(prod_sh);
      acc_in   = acc_ff + scaled;
   end

   // plane component and magnitude
   always_comb begin
      v_in = plane_ff[0] ? (a_ff + $signed(cm_rdata)) : (a_ff - $signed(cm_rdata));
      vmag = v_in[63] ? 64'(-v_in) : 64'(v_in);
   end

   // square root and divide steps
   always_comb begin
      sqrt_bit = 64'd1 << {step_ff[4:0], 1'b0};
      sqrt_try = res_ff + sqrt_bit;
      rem_in   = {rem_ff, num_ff[step_ff]};
      len_ext  = {1'b0, res_ff[32:0]};
   end

   // saturation of the quotient
   always_comb begin
      if (neg_ff[comp_ff]) begin
         q_sat = (q_ff > 64'h8000_0000) ? 64'h8000_0000 : q_ff;
         coef  = 32'(-q_sat);
      end else begin
         q_sat = (q_ff > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : q_ff;
         coef  = q_sat[31:0];
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         plane_ff     <= '0;
         comp_ff      <= '0;
         step_ff      <= '0;
      end else begin
         if (out_free && state_ff == S_EMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept && req_data.start_compute) begin
                  cnt_ff   <= '0;
                  acc_ff   <= '0;
                  state_ff <= S_MREAD;
               end
            end
            S_MREAD: state_ff <= S_MMUL;
            S_MMUL:  state_ff <= S_MACC;
            S_MACC: begin
               acc_ff <= (cnt_ff[1:0] == 2'd3) ? '0 : acc_in;
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd63) begin
                  plane_ff <= '0;
                  comp_ff  <= '0;
                  state_ff <= S_RDA;
               end else begin
                  state_ff <= S_MREAD;
               end
            end
            S_RDA: state_ff <= S_RDB;
            S_RDB: begin
               a_ff     <= $signed(cm_rdata);
               state_ff <= S_CMB;
            end
            S_CMB: begin
               mag_ff[comp_ff] <= vmag;
               neg_ff[comp_ff] <= v_in[63];
               if (comp_ff == 2'd0 || vmag > mx_ff) begin
                  mx_ff <= vmag;
               end
               comp_ff  <= comp_ff + 2'd1;
               state_ff <= (comp_ff == 2'd3) ? S_NORM : S_RDA;
            end
            S_NORM: begin
               if (mx_ff == '0) begin
                  degen_ff <= 1'b1;
                  state_ff <= S_EMIT;
               end else if (mx_ff[63:31] != '0) begin
                  for (int c = 0; c < 4; c++) begin
                     mag_ff[c] <= mag_ff[c] >> 1;
                  end
                  mx_ff <= mx_ff >> 1;
               end else if (!mx_ff[30]) begin
                  for (int c = 0; c < 4; c++) begin
                     mag_ff[c] <= mag_ff[c] << 1;
                  end
                  mx_ff <= mx_ff << 1;
               end else begin
                  degen_ff <= 1'b0;
                  sum_ff   <= '0;
                  state_ff <= S_SQM;
               end
            end
            S_SQM: state_ff <= S_SQA;
            S_SQA: begin
               if (comp_ff == 2'd2) begin
                  comp_ff  <= '0;
                  n_ff     <= sum_ff + 64'(prod_ff);
                  res_ff   <= '0;
                  step_ff  <= 6'd31;
                  state_ff <= S_SQRT;
               end else begin
                  sum_ff   <= sum_ff + 64'(prod_ff);
                  comp_ff  <= comp_ff + 2'd1;
                  state_ff <= S_SQM;
               end
            end
            S_SQRT: begin
               if (n_ff >= sqrt_try) begin
                  n_ff   <= n_ff - sqrt_try;
                  res_ff <= (res_ff >> 1) + sqrt_bit;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               step_ff <= step_ff - 6'd1;
               if (step_ff == 6'd0) begin
                  state_ff <= S_CHK;
               end
            end
            S_CHK: begin
               if (res_ff == '0) begin
                  degen_ff <= 1'b1;
                  state_ff <= S_EMIT;
               end else begin
                  state_ff <= S_DIVI;
               end
            end
            S_DIVI: begin
               num_ff   <= mag_ff[comp_ff] << FRAC_BITS;
               rem_ff   <= '0;
               q_ff     <= '0;
               step_ff  <= 6'd63;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (rem_in >= len_ext) begin
                  rem_ff <= 33'(rem_in - len_ext);
                  q_ff   <= {q_ff[62:0], 1'b1};
               end else begin
                  rem_ff <= rem_in[32:0];
                  q_ff   <= {q_ff[62:0], 1'b0};
               end
               step_ff <= step_ff - 6'd1;
               if (step_ff == 6'd0) begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_ff.plane_number <= plane_ff;
                  rsp_ff.component    <= comp_ff;
                  rsp_ff.coefficient  <= degen_ff ? '0 : $signed(coef);
                  rsp_ff.degenerate   <= degen_ff;
                  rsp_ff.final_result <= (plane_ff == 3'd5) && (comp_ff == 2'd3);
                  comp_ff <= comp_ff + 2'd1;
                  if (comp_ff == 2'd3) begin
                     if (plane_ff == 3'd5) begin
                        state_ff <= S_IDLE;
                     end else begin
                        plane_ff <= plane_ff + 3'd1;
                        state_ff <= S_RDA;
                     end
                  end else begin
                     state_ff <= degen_ff ? S_EMIT : S_DIVI;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_final_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.final_result |->
         rsp_data.plane_number == 3'd5 && rsp_data.component == 2'd3)
      else $error("final item not on last coefficient");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |-> rsp_data.coefficient == '0)
      else $error("degenerate plane with nonzero coefficient");

   a_plane_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.plane_number <= 3'd5)
      else $error("plane number out of range");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.start_compute |=> req_stall)
      else $error("input taken during compute");
`endif

endmodule

`default_nettype wire
